// ===== src/ksi_pkg.sv =====
// Package for the k smallest sorted insertion unit.
// Holds field widths, command codes, the controller state type and the
// command and status structures between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksi_pkg;

   // Field widths of the transactions and of the keep count register.
   localparam int KEEP_W = 6;
   localparam int DIST_W = 32;
   localparam int PIDX_W = 16;
   localparam int CMD_W  = 2;
   localparam int FILL_W = 6;

   // Command codes carried on the request side.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

   // Reset value of the keep count register.
   localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_REPORT,
      ST_DRAIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic update;      // apply insert or clear to the list
      logic report;      // load the insert or clear result
      logic drain_step;  // load the next drained entry
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // the result register can take a new result
      logic drain_last;  // the current drain entry is the last held one
      logic list_empty;  // no entries are held
   } ctrl_sts_type;

endpackage : ksi_pkg

`default_nettype wire

// ===== src/ksi_ctrl.sv =====
// Controller state machine of the k smallest sorted insertion unit.
// Sequences capture, list update, result report and drain steps.
// Depends on ksi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksi_ctrl
   import ksi_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic [CMD_W-1:0] req_command,
   output logic                  req_tready,
   input  wire ctrl_sts_type     sts,
   output ctrl_cmd_type          cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_command) inside
                  CMD_INSERT, CMD_CLEAR: begin
                     state_in = ST_UPDATE;
                  end
                  CMD_DRAIN: begin
                     state_in = sts.list_empty ? ST_IDLE : ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (sts.out_free && sts.drain_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs to the request port and the datapath.
   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_REPORT: begin
            cmd.report = sts.out_free;
         end
         ST_DRAIN: begin
            cmd.drain_step = sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule : ksi_ctrl

`default_nettype wire

// ===== src/ksi_datapath.sv =====
// Datapath of the k smallest sorted insertion unit: the row of
// compare-and-shift cells, the fill count, the keep count register and the
// result register. Depends on ksi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksi_datapath
   import ksi_pkg::*;
#(
   parameter int MAX_KEEP = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Configuration.
   input  wire logic              csr_wr_en,
   input  wire logic [KEEP_W-1:0] csr_wr_data,
   // Request payload.
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [DIST_W-1:0] req_distance,
   input  wire logic [PIDX_W-1:0] req_point_index,
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DIST_W-1:0]      rsp_entry_distance,
   output logic [PIDX_W-1:0]      rsp_entry_index,
   output logic [FILL_W-1:0]      rsp_fill_count,
   output logic                   rsp_list_full,
   output logic                   rsp_accepted,
   output logic                   rsp_last,
   // Controller link.
   input  wire ctrl_cmd_type      cmd,
   output ctrl_sts_type           sts
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int W     = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

   // Keep count clamped to 1..MAX_KEEP.
   function automatic logic [CNT_W-1:0] eff_keep(input logic [KEEP_W-1:0] value);
      logic [W-1:0] w;
      begin
         w = W'(value);
         if (w == '0) begin
            w = W'(1);
         end else if (w > W'(MAX_KEEP)) begin
            w = W'(MAX_KEEP);
         end
         return CNT_W'(w);
      end
   endfunction

   // Registers.
   logic [KEEP_W-1:0] keep_ff;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [DIST_W-1:0] cell_dist_ff [MAX_KEEP];
   logic [PIDX_W-1:0] cell_pidx_ff [MAX_KEEP];
   logic [DIST_W-1:0] cell_dist_in [MAX_KEEP];
   logic [PIDX_W-1:0] cell_pidx_in [MAX_KEEP];
   logic [CMD_W-1:0]  item_cmd_ff;
   logic [DIST_W-1:0] item_dist_ff;
   logic [PIDX_W-1:0] item_pidx_ff;
   logic              acc_ff, acc_in;
   logic [IDX_W-1:0]  cnt_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [PIDX_W-1:0] rsp_pidx_ff, rsp_pidx_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic              rsp_last_ff, rsp_last_in;

   // Combinational signals.
   logic [CNT_W-1:0]    keep_eff;
   logic                list_full;
   logic [CNT_W-1:0]    n_new;
   logic [CNT_W-1:0]    last_pos;
   logic [MAX_KEEP-1:0] less;
   logic [MAX_KEEP-1:0] goes_at;
   logic [MAX_KEEP-1:0] tail_sel;
   logic                worst_less;
   logic                drain_last;
   logic [IDX_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    held_m1;
   logic [W-1:0]        held_w;

   assign keep_eff  = eff_keep(keep_ff);
   assign list_full = (held_ff == keep_eff);
   assign held_m1   = held_ff - CNT_W'(1);
   assign held_w    = W'(held_ff);

   // Size of the list after an accepted insert, and its last position.
   assign n_new    = list_full ? keep_eff : (held_ff + CNT_W'(1));
   assign last_pos = n_new - CNT_W'(1);

   // Each cell compares the candidate with its own entry in parallel.
   // Within the held entries the compare results rise monotonically, so the
   // insertion point is the first position whose flag is set.
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         less[j] = (item_dist_ff < cell_dist_ff[j]) ||
                   ((item_dist_ff == cell_dist_ff[j]) && (item_pidx_ff < cell_pidx_ff[j]));
         tail_sel[j] = (CNT_W'(j) == last_pos);
         if (CNT_W'(j) < last_pos) begin
            goes_at[j] = less[j];
         end else begin
            goes_at[j] = tail_sel[j];
         end
      end
   end

   // A full list takes the candidate only if it orders before the worst entry.
   assign worst_less = |(less & tail_sel);
   assign acc_in     = !list_full || worst_less;

   // Next contents of the cell row for an insert.
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         cell_dist_in[j] = cell_dist_ff[j];
         cell_pidx_in[j] = cell_pidx_ff[j];
         if (CNT_W'(j) < n_new) begin
            if (j > 0 && goes_at[(j > 0) ? j - 1 : 0]) begin
               cell_dist_in[j] = cell_dist_ff[(j > 0) ? j - 1 : 0];
               cell_pidx_in[j] = cell_pidx_ff[(j > 0) ? j - 1 : 0];
            end else if (goes_at[j]) begin
               cell_dist_in[j] = item_dist_ff;
               cell_pidx_in[j] = item_pidx_ff;
            end
         end
      end
   end

   // The cell row is written only by an accepted insert.
   always_ff @(posedge clock) begin
      if (cmd.update && (item_cmd_ff == CMD_INSERT) && acc_in) begin
         for (int j = 0; j < MAX_KEEP; j++) begin
            cell_dist_ff[j] <= cell_dist_in[j];
            cell_pidx_ff[j] <= cell_pidx_in[j];
         end
      end
   end

   // Fill count: cleared, grown by inserts, trimmed when the keep count drops.
   always_comb begin
      held_in = held_ff;
      if (csr_wr_en) begin
         if (held_ff > eff_keep(csr_wr_data)) held_in = eff_keep(csr_wr_data);
      end else if (cmd.update) begin
         if (item_cmd_ff == CMD_CLEAR) begin
            held_in = '0;
         end else if (acc_in) begin
            held_in = n_new;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= KEEP_RESET;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) keep_ff <= csr_wr_data;
         held_ff <= held_in;
         if (cmd.report || cmd.drain_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, insert outcome and drain position.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff  <= req_command;
         item_dist_ff <= req_distance;
         item_pidx_ff <= req_point_index;
         cnt_ff       <= '0;
      end else if (cmd.drain_step) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      if (cmd.update) acc_ff <= acc_in;
   end

   // Single read port on the cell row: drain position or the worst entry.
   assign rd_idx     = (cmd.drain_step) ? cnt_ff : held_m1[IDX_W-1:0];
   assign drain_last = (CNT_W'(cnt_ff) == held_m1);

   // Next result.
   always_comb begin
      rsp_dist_in = cell_dist_ff[rd_idx];
      rsp_pidx_in = cell_pidx_ff[rd_idx];
      rsp_fill_in = held_w[FILL_W-1:0];
      rsp_full_in = list_full;
      rsp_acc_in  = 1'b0;
      rsp_last_in = 1'b1;
      if (cmd.drain_step) begin
         rsp_last_in = drain_last;
      end else if (item_cmd_ff == CMD_CLEAR) begin
         rsp_dist_in = '0;
         rsp_pidx_in = '0;
         rsp_fill_in = '0;
         rsp_full_in = 1'b0;
      end else begin
         rsp_acc_in = acc_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.report || cmd.drain_step) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_pidx_ff <= rsp_pidx_in;
         rsp_fill_ff <= rsp_fill_in;
         rsp_full_ff <= rsp_full_in;
         rsp_acc_ff  <= rsp_acc_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_entry_distance = rsp_dist_ff;
   assign rsp_entry_index    = rsp_pidx_ff;
   assign rsp_fill_count     = rsp_fill_ff;
   assign rsp_list_full      = rsp_full_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_last           = rsp_last_ff;

   // Status to the controller.
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;
   assign sts.drain_last = drain_last;
   assign sts.list_empty = (held_ff == '0);

endmodule : ksi_datapath

`default_nettype wire

// ===== src/k_smallest_sorted_insert_unit.sv =====
// Keeps the keep_count smallest (distance, point index) pairs in ascending
// order in a row of compare-and-shift cells. Each request transaction is taken
// in the idle state; an insert or a clear then updates the cell row and, once
// the result register is free, loads its result, so the next request waits for
// both steps. A drain reads the held entries out in order, one result for
// each, through the single read port of the row, each step waiting while the
// result register is occupied; a drain of an empty list or a reserved command
// gives no result. A result waiting in the output register does not stop the
// next request from being taken. The user must write the keep count only while
// the unit is idle; the block itself does not enforce it. Lowering it drops the
// worst entries at once. Depends on ksi_pkg, ksi_ctrl and ksi_datapath.
`timescale 1ns / 1ps
`default_nettype none

module k_smallest_sorted_insert_unit
   import ksi_pkg::*;
#(
   parameter int MAX_KEEP = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Configuration.
   input  wire logic              csr_wr_en,
   input  wire logic [KEEP_W-1:0] csr_wr_data,   // keep_count
   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [47:0]       req_tdata,     // distance[31:0], point_index[47:32]
   input  wire logic [CMD_W-1:0]  req_tuser,     // command[1:0]
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [55:0]            rsp_tdata,     // entry_distance[31:0], entry_index[47:32],
                                                 // fill_count[53:48], list_full[54],
                                                 // accepted[55]
   output logic                   rsp_tlast      // last
);

   ctrl_cmd_type      cmd;
   ctrl_sts_type      sts;
   logic [DIST_W-1:0] entry_distance;
   logic [PIDX_W-1:0] entry_index;
   logic [FILL_W-1:0] fill_count;
   logic              list_full;
   logic              accepted;

   // Controller.
   ksi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Datapath.
   ksi_datapath #(
      .MAX_KEEP (MAX_KEEP)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_command        (req_tuser),
      .req_distance       (req_tdata[31:0]),
      .req_point_index    (req_tdata[47:32]),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_entry_distance (entry_distance),
      .rsp_entry_index    (entry_index),
      .rsp_fill_count     (fill_count),
      .rsp_list_full      (list_full),
      .rsp_accepted       (accepted),
      .rsp_last           (rsp_tlast),
      .cmd                (cmd),
      .sts                (sts)
   );

   // Result packing.
   assign rsp_tdata = {accepted, list_full, fill_count, entry_index, entry_distance};

endmodule : k_smallest_sorted_insert_unit

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for k_smallest_sorted_insert_unit.
// Holds its own model of the sorted k-smallest list inside a small scoreboard
// class and drives random request, result and keep count traffic. Depends on ksi_pkg.
`timescale 1ns / 1ps

module tb_top
   import ksi_pkg::*;
();

   localparam int KEEP_MAX    = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 7;

   // One expected result transaction.
   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [PIDX_W-1:0] index;
      logic [FILL_W-1:0] fill;
      logic              full;
      logic              accepted;
      logic              last;
   } neighbour_result_type;

   // Tracks the list contents and checks every result transaction in order.
   class topk_scoreboard;
      logic [DIST_W-1:0] dist_row [KEEP_MAX];
      logic [PIDX_W-1:0] idx_row [KEEP_MAX];
      int unsigned       held;
      logic [KEEP_W-1:0] keep_reg;
      neighbour_result_type pending_results [$];
      int unsigned       errors;
      int unsigned       requests;
      int unsigned       results;
      int unsigned       taken;
      int unsigned       dropped;

      function new();
         held     = 0;
         keep_reg = KEEP_RESET;
         errors   = 0;
         requests = 0;
         results  = 0;
         taken    = 0;
         dropped  = 0;
      endfunction

      // A keep count of zero acts as one; anything above the row length saturates.
      function int unsigned keep_limit();
         int unsigned k;
         k = 32'(keep_reg);
         if (k == 0) k = 1;
         if (k > KEEP_MAX) k = KEEP_MAX;
         return k;
      endfunction

      // Lowering the keep count drops the worst entries straight away.
      function void write_keep(logic [KEEP_W-1:0] value);
         keep_reg = value;
         if (held > keep_limit()) held = keep_limit();
      endfunction

      // Pairs order by distance first and by point index on a tie.
      function bit orders_before(logic [DIST_W-1:0] d0, logic [PIDX_W-1:0] i0,
                                 logic [DIST_W-1:0] d1, logic [PIDX_W-1:0] i1);
         if (d0 != d1) return d0 < d1;
         return i0 < i1;
      endfunction

      function void push_result(logic [DIST_W-1:0] d, logic [PIDX_W-1:0] i, int unsigned fill,
                                bit full, bit acc, bit last);
         neighbour_result_type r;
         r.distance = d;
         r.index    = i;
         r.fill     = fill[FILL_W-1:0];
         r.full     = full;
         r.accepted = acc;
         r.last     = last;
         pending_results.push_back(r);
      endfunction

      // Applies one accepted request transaction and queues the results it causes.
      function void note_request(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] dist_key,
                                 logic [PIDX_W-1:0] pidx);
         int unsigned k;
         int unsigned n;
         int unsigned pos;
         int          j;
         bit          take;
         k = keep_limit();
         requests++;
         if (held > k) held = k;
         case (cmd)
            CMD_INSERT: begin
               take = 1'b1;
               if (held >= k) begin
                  n = k;
                  if (!orders_before(dist_key, pidx, dist_row[n-1], idx_row[n-1]))
                     take = 1'b0;
               end else begin
                  n = held + 1;
               end
               if (take) begin
                  // An equal pair already held stays ahead of the new one.
                  pos = 0;
                  while (pos < n - 1 &&
                         !orders_before(dist_key, pidx, dist_row[pos], idx_row[pos]))
                     pos++;
                  for (j = int'(n) - 1; j > int'(pos); j--) begin
                     dist_row[j] = dist_row[j-1];
                     idx_row[j]  = idx_row[j-1];
                  end
                  dist_row[pos] = dist_key;
                  idx_row[pos]  = pidx;
                  held = n;
                  taken++;
               end else begin
                  dropped++;
               end
               push_result(dist_row[held-1], idx_row[held-1], held, held == k, take, 1'b1);
            end
            CMD_CLEAR: begin
               held = 0;
               push_result('0, '0, 0, 1'b0, 1'b0, 1'b1);
            end
            CMD_DRAIN: begin
               for (j = 0; j < int'(held); j++)
                  push_result(dist_row[j], idx_row[j], held, held == k, 1'b0,
                              j + 1 == int'(held));
            end
            default: begin
               // The reserved command is ignored.
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] expected_value,
                                  logic [31:0] actual_value);
         if (expected_value !== actual_value) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected_value, actual_value);
            errors++;
         end
      endfunction

      // Compares one result transaction with the oldest expectation.
      function void check_response(logic [55:0] data, logic last);
         neighbour_result_type r;
         results++;
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation waiting: data %h last %b",
                   data, last);
            errors++;
            return;
         end
         r = pending_results.pop_front();
         compare_field("entry_distance", r.distance, data[31:0]);
         compare_field("entry_index", 32'(r.index), 32'(data[47:32]));
         compare_field("fill_count", 32'(r.fill), 32'(data[53:48]));
         compare_field("list_full", 32'(r.full), 32'(data[54]));
         compare_field("accepted", 32'(r.accepted), 32'(data[55]));
         compare_field("last", 32'(r.last), 32'(last));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       req_tdata;     // distance[31:0], point_index[47:32]
   logic [CMD_W-1:0]  req_tuser;     // command[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [55:0]       rsp_tdata;     // entry_distance[31:0], entry_index[47:32],
                                     // fill_count[53:48], list_full[54], accepted[55]
   logic              rsp_tlast;     // last

   topk_scoreboard    sb;
   bit                steady;
   int unsigned       cycle_count = 0;
   int unsigned       keep_writes;
   logic [KEEP_W-1:0] keep_plan [PHASES];
   int unsigned       plan_items [PHASES];

   k_smallest_sorted_insert_unit #(
      .MAX_KEEP(KEEP_MAX)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls at random unless a steady stretch is running.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 28);
   end

   // Both handshakes are sampled here so that prediction always precedes checking.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[31:0], req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 28);
   endfunction

   // Offers one request transaction and returns once it has been taken.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DIST_W-1:0] dist_key,
                               input logic [PIDX_W-1:0] pidx);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pidx, dist_key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every expected result has arrived, then lets the unit settle.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_keep_count(input logic [KEEP_W-1:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.write_keep(value);
      keep_writes++;
      csr_wr_en <= 1'b0;
   endtask

   // Random request, mostly inserts; narrow ranges give plenty of ties.
   task automatic random_request();
      int unsigned       roll;
      int unsigned       mode;
      logic [CMD_W-1:0]  cmd;
      logic [DIST_W-1:0] dist_key;
      logic [PIDX_W-1:0] pidx;
      roll = $urandom_range(0, 99);
      mode = $urandom_range(0, 2);
      if (roll < 87)      cmd = CMD_INSERT;
      else if (roll < 94) cmd = CMD_DRAIN;
      else if (roll < 97) cmd = CMD_CLEAR;
      else                cmd = CMD_RSVD;
      case (mode)
         0: begin
            dist_key = $urandom;
            pidx     = 16'($urandom_range(0, 65535));
         end
         1: begin
            dist_key = $urandom_range(0, 7);
            pidx     = 16'($urandom_range(0, 3));
         end
         default: begin
            dist_key = $urandom_range(0, 1000);
            pidx     = 16'($urandom_range(0, 65535));
         end
      endcase
      send_request(cmd, dist_key, pidx);
   endtask

   initial begin
      sb          = new();
      steady      = 1'b0;
      keep_writes = 0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_INSERT;
      rsp_tready  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset keep count: field extremes, drain, reserved command, clear, empty drain.
      send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(CMD_INSERT, 32'h0000_0000, 16'h0000);
      send_request(CMD_INSERT, 32'h0000_0000, 16'hFFFF);
      send_request(CMD_INSERT, 32'h8000_0000, 16'h8000);
      send_request(CMD_DRAIN, $urandom, 16'($urandom_range(0, 65535)));
      send_request(CMD_RSVD, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(CMD_CLEAR, $urandom, 16'($urandom_range(0, 65535)));
      send_request(CMD_DRAIN, 32'h0, 16'h0);

      // Small list: ties with the worst entry and with a held entry, drops.
      write_keep_count(6'd3);
      send_request(CMD_INSERT, 32'd10, 16'd5);
      send_request(CMD_INSERT, 32'd10, 16'd7);
      send_request(CMD_INSERT, 32'd20, 16'd1);
      send_request(CMD_INSERT, 32'd20, 16'd1);
      send_request(CMD_INSERT, 32'd10, 16'd7);
      send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'd0);
      send_request(CMD_INSERT, 32'd0, 16'hFFFF);
      send_request(CMD_DRAIN, 32'd0, 16'd0);

      // Lowering the keep count below the fill trims the list.
      write_keep_count(6'd1);
      send_request(CMD_DRAIN, 32'd0, 16'd0);
      send_request(CMD_INSERT, 32'd0, 16'd0);
      send_request(CMD_DRAIN, 32'd0, 16'd0);

      // Random phases, each with its own keep count.
      keep_plan[0] = 6'd63;  plan_items[0] = 45;
      keep_plan[1] = 6'd33;  plan_items[1] = 35;
      keep_plan[2] = 6'd7;   plan_items[2] = 22;
      keep_plan[3] = 6'd2;   plan_items[3] = 12;
      keep_plan[4] = 6'd0;   plan_items[4] = 10;
      keep_plan[5] = 6'd32;  plan_items[5] = 8;
      keep_plan[6] = 6'($urandom_range(0, 63));
      plan_items[6] = 18;
      for (int p = 0; p < PHASES; p++) begin
         write_keep_count(keep_plan[p]);
         // One phase runs without any idling on either side.
         steady = (p == 2);
         for (int i = 0; i < int'(plan_items[p]); i++) random_request();
      end
      steady = 1'b0;

      wait_quiet();
      $display("Ran %0d request and %0d result transactions over %0d keep count writes.",
               sb.requests, sb.results, keep_writes);
      $display("Inserts taken into the list: %0d, dropped as too large: %0d.",
               sb.taken, sb.dropped);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule : tb_top

// ===== filelist.f =====
src/ksi_pkg.sv
src/ksi_ctrl.sv
src/ksi_datapath.sv
src/k_smallest_sorted_insert_unit.sv
sim/tb_top.sv
